[src/wmoc_pkg.sv]
// Package with shared constants and controller/datapath interface types.
`timescale 1ns / 1ps
package wmoc_pkg;

  localparam int RECENT_DEPTH = 15;
  localparam int MIN_SAMPLES  = 6;
  localparam int IDX_W        = 4;
  localparam int CNT_W        = 4;
  localparam int SORT_W       = 19;

  localparam logic signed [SORT_W-1:0] SORT_PAD = {1'b0, {(SORT_W-1){1'b1}}};
  localparam logic [SORT_W-1:0] MAD_FLOOR_Q = 19'd3277;
  localparam logic [14:0] TIGHT_COEF = 15'd22938;
  localparam logic signed [15:0] SCORE_ONE = 16'sd16384;

  typedef struct packed {
    logic capture;
    logic load_vals;
    logic load_devs;
    logic sort_step;
    logic sort_odd;
    logic med_a;
    logic med_b;
    logic mad_a;
    logic mad_b;
    logic tight;
    logic span;
    logic bound;
    logic pull;
    logic write;
    logic prune;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic enough;
    logic drop;
    logic out_free;
  } stat_t;

endpackage

[src/wmoc_ctrl.sv]
// Controller state machine that sequences one transaction through the datapath.
`timescale 1ns / 1ps
module wmoc_ctrl
  import wmoc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o,
  output logic  in_stall_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOADV = 4'd1;
  localparam logic [3:0] S_SORTV = 4'd2;
  localparam logic [3:0] S_MEDA  = 4'd3;
  localparam logic [3:0] S_MEDB  = 4'd4;
  localparam logic [3:0] S_LOADD = 4'd5;
  localparam logic [3:0] S_SORTD = 4'd6;
  localparam logic [3:0] S_MADA  = 4'd7;
  localparam logic [3:0] S_MADB  = 4'd8;
  localparam logic [3:0] S_TIGHT = 4'd9;
  localparam logic [3:0] S_SPAN  = 4'd10;
  localparam logic [3:0] S_BOUND = 4'd11;
  localparam logic [3:0] S_PULL  = 4'd12;
  localparam logic [3:0] S_WRITE = 4'd13;
  localparam logic [3:0] S_PRUNE = 4'd14;
  localparam logic [3:0] S_DONE  = 4'd15;

  localparam logic [IDX_W-1:0] LAST_PASS = IDX_W'(RECENT_DEPTH - 1);

  logic [3:0]       state_q, state_d;
  logic [IDX_W-1:0] pass_q, pass_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    pass_d  = pass_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = stat_i.enough ? S_LOADV : S_WRITE;
        end
      end
      S_LOADV: begin
        cmd_o.load_vals = 1'b1;
        pass_d  = '0;
        state_d = S_SORTV;
      end
      S_SORTV: begin
        cmd_o.sort_step = 1'b1;
        cmd_o.sort_odd  = pass_q[0];
        if (pass_q == LAST_PASS) state_d = S_MEDA;
        else pass_d = pass_q + 1'b1;
      end
      S_MEDA: begin
        cmd_o.med_a = 1'b1;
        state_d = S_MEDB;
      end
      S_MEDB: begin
        cmd_o.med_b = 1'b1;
        state_d = S_LOADD;
      end
      S_LOADD: begin
        cmd_o.load_devs = 1'b1;
        pass_d  = '0;
        state_d = S_SORTD;
      end
      S_SORTD: begin
        cmd_o.sort_step = 1'b1;
        cmd_o.sort_odd  = pass_q[0];
        if (pass_q == LAST_PASS) state_d = S_MADA;
        else pass_d = pass_q + 1'b1;
      end
      S_MADA: begin
        cmd_o.mad_a = 1'b1;
        state_d = S_MADB;
      end
      S_MADB: begin
        cmd_o.mad_b = 1'b1;
        state_d = S_TIGHT;
      end
      S_TIGHT: begin
        cmd_o.tight = 1'b1;
        state_d = S_SPAN;
      end
      S_SPAN: begin
        cmd_o.span = 1'b1;
        state_d = S_BOUND;
      end
      S_BOUND: begin
        cmd_o.bound = 1'b1;
        state_d = S_PULL;
      end
      S_PULL: begin
        cmd_o.pull = 1'b1;
        state_d = S_WRITE;
      end
      S_WRITE: begin
        cmd_o.write = 1'b1;
        state_d = S_PRUNE;
      end
      S_PRUNE: begin
        if (stat_i.drop) cmd_o.prune = 1'b1;
        else state_d = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pass_q  <= '0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
    end
  end

endmodule

[src/wmoc_dp.sv]
// Datapath: sample rings, sort array, median and bound arithmetic, output register.
`timescale 1ns / 1ps
module wmoc_dp
  import wmoc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output stat_t               stat_o,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic signed [15:0]  raw_score_i,
  input  logic [16:0]         confidence_i,
  input  logic [31:0]         timestamp_s_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic signed [15:0]  adjusted_score_o,
  output logic [16:0]         sample_weight_o,
  output logic                outlier_hit_o,
  output logic [3:0]          recent_count_o
);

  logic [15:0]              window_q;
  logic signed [15:0]       score_q [RECENT_DEPTH];
  logic [31:0]              time_q  [RECENT_DEPTH];
  logic [CNT_W-1:0]         vc_q;
  logic [IDX_W-1:0]         head_q;
  logic signed [SORT_W-1:0] sort_q [RECENT_DEPTH];
  logic signed [SORT_W-1:0] sort_d [RECENT_DEPTH];

  logic signed [15:0]       s_q, adj_q;
  logic [16:0]              conf_q, weight_q, t16_q;
  logic [31:0]              now_q;
  logic                     hit_q;
  logic signed [SORT_W-1:0] a_q;
  logic signed [17:0]       m2_q;
  logic [SORT_W-1:0]        mad_q;
  logic [36:0]              prod_q;
  logic signed [23:0]       lo_q, hi_q;

  logic                     out_valid_q;
  logic signed [15:0]       out_adj_q;
  logic [16:0]              out_w_q;
  logic                     out_hit_q;
  logic [3:0]               out_cnt_q;

  // Input conditioning.
  logic signed [15:0] s_c;
  logic [16:0]        conf_c;
  logic [17:0]        w3;
  always_comb begin
    if (raw_score_i > SCORE_ONE) s_c = SCORE_ONE;
    else if (raw_score_i < -SCORE_ONE) s_c = -SCORE_ONE;
    else s_c = raw_score_i;
    conf_c = (confidence_i > 17'd65536) ? 17'd65536 : confidence_i;
    w3 = {1'b0, conf_c} + {conf_c, 1'b0} + 18'd2;
  end

  // Which ring slots hold one of the newest vc_q samples.
  logic [RECENT_DEPTH-1:0] slot_ok;
  always_comb begin
    logic [IDX_W:0] rank;
    for (int i = 0; i < RECENT_DEPTH; i++) begin
      rank = {1'b0, head_q} + (IDX_W+1)'(RECENT_DEPTH - 1 - i);
      if (rank >= (IDX_W+1)'(RECENT_DEPTH)) rank = rank - (IDX_W+1)'(RECENT_DEPTH);
      slot_ok[i] = (rank < (IDX_W+1)'(vc_q));
    end
  end

  // Sort array: load, and odd-even transposition steps.
  always_comb begin
    logic signed [SORT_W-1:0] dv;
    dv = '0;
    for (int i = 0; i < RECENT_DEPTH; i++) sort_d[i] = sort_q[i];
    if (cmd_i.load_vals) begin
      for (int i = 0; i < RECENT_DEPTH; i++)
        sort_d[i] = slot_ok[i] ? SORT_W'(score_q[i]) : SORT_PAD;
    end else if (cmd_i.load_devs) begin
      for (int i = 0; i < RECENT_DEPTH; i++) begin
        dv = (SORT_W'(score_q[i]) <<< 1) - SORT_W'(m2_q);
        if (dv < 0) dv = -dv;
        sort_d[i] = slot_ok[i] ? dv : SORT_PAD;
      end
    end else if (cmd_i.sort_step) begin
      for (int i = 0; i < RECENT_DEPTH - 1; i++) begin
        if ((i % 2) == int'(cmd_i.sort_odd) && sort_q[i] > sort_q[i+1]) begin
          sort_d[i]   = sort_q[i+1];
          sort_d[i+1] = sort_q[i];
        end
      end
    end
  end

  logic [IDX_W-1:0]         idx_a, idx_b;
  logic signed [SORT_W-1:0] sel_a, sel_b;
  logic [SORT_W-1:0]        mad_sum;
  assign idx_a   = IDX_W'((vc_q - 1'b1) >> 1);
  assign idx_b   = IDX_W'(vc_q >> 1);
  assign sel_a   = sort_q[idx_a];
  assign sel_b   = sort_q[idx_b];
  assign mad_sum = SORT_W'(a_q + sel_b);

  // Bound arithmetic.
  logic [16:0]        inv_c;
  logic [31:0]        tp, tr;
  logic [19:0]        mad3;
  logic [20:0]        span;
  logic signed [23:0] m4, s4, b4, px, pr;
  logic signed [15:0] pull_adj;
  always_comb begin
    inv_c = 17'd65536 - conf_q;
    tp    = 32'(inv_c) * 32'(TIGHT_COEF);
    tr    = (tp + 32'd32768) >> 16;
    mad3  = 20'(mad_q) + {mad_q, 1'b0};
    span  = 21'((prod_q + 37'd32768) >> 16);
    m4    = 24'(m2_q) <<< 1;
    s4    = 24'(s_q) <<< 2;
    b4    = (s4 < lo_q) ? lo_q : hi_q;
    px    = b4 + (b4 <<< 1) + m4;
    pr    = (px + 24'sd8) >>> 4;
    if (pr > 24'sd16384) pull_adj = SCORE_ONE;
    else if (pr < -24'sd16384) pull_adj = -SCORE_ONE;
    else pull_adj = 16'(pr);
  end

  // Pruning check against the oldest held sample.
  logic [IDX_W:0]   old_sum;
  logic [IDX_W-1:0] old_idx;
  logic [31:0]      old_t, age;
  always_comb begin
    old_sum = {1'b0, head_q} + (IDX_W+1)'(RECENT_DEPTH) - (IDX_W+1)'(vc_q);
    if (old_sum >= (IDX_W+1)'(RECENT_DEPTH)) old_sum = old_sum - (IDX_W+1)'(RECENT_DEPTH);
    old_idx = old_sum[IDX_W-1:0];
    old_t   = time_q[old_idx];
    age     = (now_q >= old_t) ? now_q - old_t : 32'd0;
  end

  assign stat_o.enough   = (vc_q >= CNT_W'(MIN_SAMPLES));
  assign stat_o.drop     = (vc_q != '0) && (age > 32'(window_q));
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  // Payload registers.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < RECENT_DEPTH; i++) sort_q[i] <= sort_d[i];
    if (cmd_i.capture) begin
      s_q      <= s_c;
      adj_q    <= s_c;
      hit_q    <= 1'b0;
      conf_q   <= conf_c;
      now_q    <= timestamp_s_i;
      weight_q <= 17'd16384 + 17'(w3 >> 2);
    end
    if (cmd_i.med_a || cmd_i.mad_a) a_q <= sel_a;
    if (cmd_i.med_b) m2_q <= 18'(a_q + sel_b);
    if (cmd_i.mad_b) mad_q <= (mad_sum < MAD_FLOOR_Q) ? MAD_FLOOR_Q : mad_sum;
    if (cmd_i.tight) t16_q <= 17'd65536 - 17'(tr);
    if (cmd_i.span) prod_q <= 37'(mad3) * 37'(t16_q);
    if (cmd_i.bound) begin
      lo_q <= m4 - $signed({3'b000, span});
      hi_q <= m4 + $signed({3'b000, span});
    end
    if (cmd_i.pull && (s4 < lo_q || s4 > hi_q)) begin
      hit_q <= 1'b1;
      adj_q <= pull_adj;
    end
    if (cmd_i.write) begin
      score_q[head_q] <= adj_q;
      time_q[head_q]  <= now_q;
    end
    if (cmd_i.emit) begin
      out_adj_q <= adj_q;
      out_w_q   <= weight_q;
      out_hit_q <= hit_q;
      out_cnt_q <= 4'(vc_q);
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q    <= 16'd300;
      vc_q        <= '0;
      head_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) window_q <= cfg_wdata_i;
      if (cmd_i.write) begin
        head_q <= (head_q == IDX_W'(RECENT_DEPTH - 1)) ? '0 : head_q + 1'b1;
        if (vc_q < CNT_W'(RECENT_DEPTH)) vc_q <= vc_q + 1'b1;
      end else if (cmd_i.prune) begin
        vc_q <= vc_q - 1'b1;
      end
      if (cmd_i.emit) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign adjusted_score_o = out_adj_q;
  assign sample_weight_o  = out_w_q;
  assign outlier_hit_o    = out_hit_q;
  assign recent_count_o   = out_cnt_q;

endmodule

[src/windowed_mad_outlier_clamp.sv]
// Top level of the windowed median/MAD outlier clamp.
// Usage: each input transaction carries a Q2.14 score, a Q1.16 confidence and a
// timestamp in seconds. The block returns exactly one output transaction per
// input transaction with the adjusted score, the sample weight, an outlier flag
// and the number of in-window samples still held.
// With fewer than six held samples the history write and pruning follow the
// input transaction directly. Otherwise the held samples are sorted twice by
// an odd-even transposition network of 15 passes (once for the median, once for
// the absolute deviations), followed by a short bound and pull sequence. Every
// aged-out sample is dropped in its own prune step (up to 14, since the new
// sample always stays). One transaction is in the datapath at a time;
// in_stall_o is high from the accepting edge until the result moves to the
// output register, and the next input transaction is taken in the idle state
// that follows.
// The result waits in an output register: while the receiver holds out_stall_i
// high the result stays stable and the block still accepts and works on the
// next input transaction, then holds it with in_stall_o high until the waiting
// result leaves.
// The window register is written by cfg_we_i/cfg_wdata_i and resets to 300.
// Reset empties the sample history and clears the output valid.
`timescale 1ns / 1ps
module windowed_mad_outlier_clamp
  import wmoc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] raw_score_i,
  input  logic [16:0]        confidence_i,
  input  logic [31:0]        timestamp_s_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] adjusted_score_o,
  output logic [16:0]        sample_weight_o,
  output logic               outlier_hit_o,
  output logic [3:0]         recent_count_o
);

  // Commands from the controller and status back from the datapath.
  cmd_t  cmd;
  stat_t stat;

  wmoc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  wmoc_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .raw_score_i      (raw_score_i),
    .confidence_i     (confidence_i),
    .timestamp_s_i    (timestamp_s_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .adjusted_score_o (adjusted_score_o),
    .sample_weight_o  (sample_weight_o),
    .outlier_hit_o    (outlier_hit_o),
    .recent_count_o   (recent_count_o)
  );

endmodule
